// ===== rtl/tfr_pkg.sv =====
// ----------------------------------------------------------------------------
// tfr_pkg
// Shared types and codes for the tied fractional ranker.
// ----------------------------------------------------------------------------
package tfr_pkg;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_READY = 2'd1;
    localparam logic [1:0] STATUS_RANGE     = 2'd2;

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_READ = 1'b1;

    localparam int RANK_WIDTH = 11;

    // controller -> datapath
    typedef struct packed {
        logic load_clear;    // start a new set
        logic load_write;    // store sample at count
        logic rd_issue;      // read rank store at index
        logic sort_init;     // i <= 1
        logic ins_start;     // key <= store[i], j <= i
        logic ins_cmp_rd;    // read order[j-1] value
        logic ins_shift;     // order[j] <= order[j-1], j--
        logic ins_place;     // order[j] <= key, i++
        logic run_init;      // start run scan
        logic run_step;      // fetch order[j] value
        logic run_eval;      // compare and advance
        logic fill_step;     // write rank for one run member
        logic set_ready;
    } tfr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic ranks_ready;
        logic full;
        logic i_done;        // i >= n
        logic j_zero;
        logic cmp_gt;        // order[j-1] value > key
        logic j_at_n;        // run scan reached n
        logic cut;
        logic fill_done;
        logic n_zero;
    } tfr_sts_t;

endpackage

// ===== rtl/tied_fractional_ranker_unit.sv =====
// ----------------------------------------------------------------------------
// tied_fractional_ranker_unit
// Fractional ranking with ties over one loaded column of samples.
// ----------------------------------------------------------------------------
// A load beat is written when accepted, unless the set is full; a read beat gives its result in the next cycle.
// A last-sample beat runs an insertion sort over the loaded samples, then
//   the run scan and rank fill.
// Throughput: one item at a time; the memory ports set the sort pace.
// Reset: rst_n clears count, ready flag, tolerance and the sequencer;
//   memories are not cleared.
module tied_fractional_ranker_unit import tfr_pkg::*; #(
    parameter int MAX_SAMPLES  = 1024,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    action,
    input  logic [SAMPLE_WIDTH-1:0] sample_value,
    input  logic                    last_sample,
    input  logic [9:0]              rank_index,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [RANK_WIDTH-1:0]   rank_times_two,
    output logic [1:0]              status,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [31:0]             cfg_data
);
    tfr_cmd_t              cmd;
    tfr_sts_t              sts;
    logic [31:0]           tol_reg;
    logic [RANK_WIDTH-1:0] rank_rd;
    logic [1:0]            status_rd;

    // tolerance register, always writable
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (cfg_valid)
            tol_reg <= cfg_data;
    end

    tfr_controller u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .last_sample (last_sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .sts         (sts)
    );

    tfr_datapath #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .sample_value  (sample_value),
        .rank_index    (rank_index),
        .tie_tolerance (tol_reg),
        .rank_rd       (rank_rd),
        .status_rd     (status_rd)
    );

    // rank is zero whenever the status reports an error
    assign status         = status_rd;
    assign rank_times_two = (status_rd == STATUS_OK) ? rank_rd : '0;

endmodule

// ===== rtl/tfr_datapath.sv =====
// ----------------------------------------------------------------------------
// tfr_datapath
// Sample, order and rank memories; insertion sort and run scan registers.
// ----------------------------------------------------------------------------
module tfr_datapath import tfr_pkg::*; #(
    parameter int MAX_SAMPLES  = 1024,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tfr_cmd_t                cmd,
    output tfr_sts_t                sts,
    input  logic [SAMPLE_WIDTH-1:0] sample_value,
    input  logic [9:0]              rank_index,
    input  logic [31:0]             tie_tolerance,
    output logic [RANK_WIDTH-1:0]   rank_rd,
    output logic [1:0]              status_rd
);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = AW + 1;
    localparam int DW = ((SAMPLE_WIDTH > 32) ? SAMPLE_WIDTH : 32) + 1;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_SAMPLES);

    logic [SAMPLE_WIDTH-1:0] sample_mem [MAX_SAMPLES];
    logic [AW-1:0]           order_mem  [MAX_SAMPLES];
    logic [RANK_WIDTH-1:0]   rank_mem   [MAX_SAMPLES];

    logic [CW-1:0] count_reg, count_next;
    logic          ready_reg, ready_next;
    logic [CW-1:0] i_reg, j_reg, start_reg, fill_reg;
    logic [SAMPLE_WIDTH-1:0] key_reg, first_reg, rd_val_reg;
    logic [AW-1:0] rd_ord_reg;
    logic [AW-1:0] ord_j_reg;
    logic [AW-1:0] key_idx_reg;
    logic          key_load_reg;
    logic [SAMPLE_WIDTH-1:0] key_val;
    logic [SAMPLE_WIDTH-1:0] flip_in;
    logic [SAMPLE_WIDTH-1:0] diff;
    logic [CW:0]             r2_full;

    assign flip_in = sample_value ^ {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    always_comb
    begin
        count_next = count_reg;
        ready_next = ready_reg;
        if (cmd.load_clear)
        begin
            count_next = '0;
            ready_next = 1'b0;
        end
        if (cmd.load_write)
            count_next = (cmd.load_clear ? CW'(0) : count_reg) + CW'(1);
        if (cmd.set_ready)
            ready_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ready_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ready_reg <= ready_next;
        end
    end

    // sample memory: one write port, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load_write)
            sample_mem[cmd.load_clear ? AW'(0) : count_reg[AW-1:0]] <= flip_in;
        rd_val_reg <= sample_mem[cmd.ins_start ? i_reg[AW-1:0] : ord_j_reg];
    end

    // order memory: registered reads at fill and at j (or j-1), one write at j (or at 0 on sort_init)
    always_ff @(posedge clk)
    begin
        rd_ord_reg <= order_mem[fill_reg[AW-1:0]];
        if (cmd.ins_cmp_rd)
            ord_j_reg <= order_mem[j_reg[AW-1:0] - AW'(1)];
        else if (cmd.run_step)
            ord_j_reg <= order_mem[j_reg[AW-1:0]];
        if (cmd.sort_init)
            order_mem[AW'(0)] <= '0;
        else if (cmd.ins_shift)
            order_mem[j_reg[AW-1:0]] <= ord_j_reg;
        else if (cmd.ins_place)
            order_mem[j_reg[AW-1:0]] <= key_idx_reg;
    end

    assign r2_full = {1'b0, start_reg} + {1'b0, j_reg} - (CW+1)'(1);

    // rank memory; read data held for the whole result beat
    always_ff @(posedge clk)
    begin
        if (cmd.fill_step)
            rank_mem[rd_ord_reg] <= RANK_WIDTH'(r2_full);
        if (cmd.rd_issue)
            rank_rd <= rank_mem[AW'(rank_index)];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            if (!ready_reg)
                status_rd <= STATUS_NOT_READY;
            else if (CW'(rank_index) >= count_reg || 32'(rank_index) >= MAX_SAMPLES)
                status_rd <= STATUS_RANGE;
            else
                status_rd <= STATUS_OK;
        end
    end

    // sort registers
    always_ff @(posedge clk)
    begin
        if (cmd.sort_init)
            i_reg <= CW'(1);
        if (cmd.ins_start)
        begin
            j_reg       <= i_reg;
            key_idx_reg <= i_reg[AW-1:0];
        end
        if (cmd.ins_shift)
            j_reg <= j_reg - CW'(1);
        if (cmd.ins_place)
            i_reg <= i_reg + CW'(1);
        if (cmd.run_init)
        begin
            start_reg <= '0;
            j_reg     <= '0;
            fill_reg  <= '0;
        end
        if (cmd.run_eval)
        begin
            if (j_reg == '0)
                first_reg <= rd_val_reg;
            else if (sts.cut)
                first_reg <= rd_val_reg;
            if (!(sts.cut && j_reg != '0))
                j_reg <= j_reg + CW'(1);
        end
        if (cmd.fill_step)
        begin
            fill_reg <= fill_reg + CW'(1);
            if (fill_reg + CW'(1) == j_reg)
            begin
                start_reg <= j_reg;
                if (j_reg != count_reg)
                    j_reg <= j_reg + CW'(1);
            end
        end
    end

    // key captured in the cycle after the ins_start read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_load_reg <= 1'b0;
        else
            key_load_reg <= cmd.ins_start;
    end

    assign key_val = key_load_reg ? rd_val_reg : key_reg;

    always_ff @(posedge clk)
    begin
        if (key_load_reg)
            key_reg <= rd_val_reg;
    end

    // sorted order keeps rd_val_reg >= first_reg, so no borrow
    assign diff = rd_val_reg - first_reg;

    assign sts.ranks_ready = ready_reg;
    assign sts.full        = (count_reg == MAX_C);
    assign sts.i_done      = (i_reg >= count_reg);
    assign sts.j_zero      = (j_reg == '0);
    assign sts.cmp_gt      = rd_val_reg > key_val;
    assign sts.j_at_n      = (j_reg == count_reg);
    assign sts.cut         = (j_reg != '0) && (DW'(diff) > DW'(tie_tolerance));
    assign sts.fill_done   = (fill_reg + CW'(1) == j_reg);
    assign sts.n_zero      = (count_reg == '0);

endmodule

// ===== rtl/tfr_controller.sv =====
// ----------------------------------------------------------------------------
// tfr_controller
// Sequencer for load, read, insertion sort and tie-run fill.
// ----------------------------------------------------------------------------
module tfr_controller import tfr_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  logic     action,
    input  logic     last_sample,
    output logic     out_valid,
    input  logic     out_stall,
    output tfr_cmd_t cmd,
    input  tfr_sts_t sts
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INSF   = 4'd1;
    localparam logic [3:0] S_OUT    = 4'd2;
    localparam logic [3:0] S_INS0   = 4'd3;
    localparam logic [3:0] S_INSK   = 4'd4;
    localparam logic [3:0] S_INSR   = 4'd5;
    localparam logic [3:0] S_INSC   = 4'd6;
    localparam logic [3:0] S_RUNR   = 4'd7;
    localparam logic [3:0] S_RUNE   = 4'd8;
    localparam logic [3:0] S_FILLR  = 4'd9;
    localparam logic [3:0] S_FILL   = 4'd10;
    localparam logic [3:0] S_RUNINI = 4'd11;
    localparam logic [3:0] S_RUNF   = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       acc;

    assign in_stall  = (state_reg != S_IDLE);
    assign acc       = in_valid && !in_stall;
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc && action == ACTION_READ)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_OUT;
                end
                else if (acc)
                begin
                    cmd.load_clear = sts.ranks_ready;
                    cmd.load_write = sts.ranks_ready || !sts.full;
                    if (last_sample)
                    begin
                        cmd.sort_init = 1'b1;
                        state_next    = S_INS0;
                    end
                end
            end
            S_INS0:
            begin
                if (sts.i_done)
                    state_next = S_RUNINI;
                else
                begin
                    cmd.ins_start = 1'b1;
                    state_next    = S_INSK;
                end
            end
            S_INSK:
                state_next = S_INSR;
            S_INSR:
            begin
                if (sts.j_zero)
                begin
                    cmd.ins_place = 1'b1;
                    state_next    = S_INS0;
                end
                else
                begin
                    cmd.ins_cmp_rd = 1'b1;
                    state_next     = S_INSF;
                end
            end
            // sample read at order[j-1]
            S_INSF:
                state_next = S_INSC;
            S_INSC:
            begin
                if (sts.cmp_gt)
                begin
                    cmd.ins_shift = 1'b1;
                    state_next    = S_INSR;
                end
                else
                begin
                    cmd.ins_place = 1'b1;
                    state_next    = S_INS0;
                end
            end
            S_RUNINI:
            begin
                if (sts.n_zero)
                begin
                    cmd.set_ready = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.run_init = 1'b1;
                    state_next   = S_RUNR;
                end
            end
            S_RUNR:
            begin
                if (sts.j_at_n)
                    state_next = S_FILLR;
                else
                begin
                    cmd.run_step = 1'b1;
                    state_next   = S_RUNF;
                end
            end
            // sample read at order[j]
            S_RUNF:
                state_next = S_RUNE;
            S_RUNE:
            begin
                cmd.run_eval = 1'b1;
                if (sts.cut)
                    state_next = S_FILLR;
                else
                    state_next = S_RUNR;
            end
            S_FILLR:
                state_next = S_FILL;
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (!sts.fill_done)
                    state_next = S_FILLR;
                else if (sts.j_at_n)
                begin
                    cmd.set_ready = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                    state_next = S_RUNR;
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/tfr_checker.sv =====
// ----------------------------------------------------------------------------
// tfr_checker
// Port-level checks for the tied fractional ranker.
// ----------------------------------------------------------------------------
module tfr_checker import tfr_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        action,
    input logic        out_valid,
    input logic        out_stall,
    input logic [10:0] rank_times_two,
    input logic [1:0]  status
);
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK || status == STATUS_NOT_READY ||
                       status == STATUS_RANGE))
        else $error("bad status code");

    a_err_rank_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STATUS_OK) |-> (rank_times_two == '0))
        else $error("rank nonzero on error");

    a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && action == ACTION_READ) |=> out_valid)
        else $error("read beat without result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status)))
        else $error("result dropped under stall");
endmodule

bind tied_fractional_ranker_unit tfr_checker u_tfr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .rank_times_two (rank_times_two),
    .status         (status)
);
